>>> hw/rtl/sctf_pkg.sv
// shared types and constants for the sector cache frequency tag manager
package sctf_pkg;

   // fixed field widths of the request and response items
   localparam int SECTOR_W = 10;
   localparam int SLOT_W   = 4;

   // one response item as handed from the scan sequencer to the output register
   typedef struct packed {
      logic              load;
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              fill;
      logic              evicted;
      logic              disk_access;
   } rsp_item_type;

endpackage

>>> hw/rtl/sctf_tag_store.sv
// tag and use count memories with one registered read port and one write port
module sctf_tag_store #(
   parameter int SLOTS      = 10,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 4
) (
   input  logic                          clock,
   input  logic [IDX_W-1:0]              rd_addr,
   output logic [sctf_pkg::SECTOR_W-1:0] rd_sector,
   output logic [COUNT_BITS-1:0]         rd_count,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  logic [sctf_pkg::SECTOR_W-1:0] wr_sector,
   input  logic [COUNT_BITS-1:0]         wr_count
);

   logic [sctf_pkg::SECTOR_W-1:0] sector_mem_ff [SLOTS];
   logic [COUNT_BITS-1:0]         count_mem_ff  [SLOTS];
   logic [sctf_pkg::SECTOR_W-1:0] rd_sector_ff;
   logic [COUNT_BITS-1:0]         rd_count_ff;

   // entries are only read below the fill count, so no clearing is needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sector_mem_ff[wr_addr] <= wr_sector;
         count_mem_ff[wr_addr]  <= wr_count;
      end
      rd_sector_ff <= sector_mem_ff[rd_addr];
      rd_count_ff  <= count_mem_ff[rd_addr];
   end

   assign rd_sector = rd_sector_ff;
   assign rd_count  = rd_count_ff;

endmodule

>>> hw/rtl/sctf_scan.sv
// slot scan sequencer with the shared compare and saturating increment unit
module sctf_scan #(
   parameter int SLOTS      = 10,
   parameter int COUNT_BITS = 16,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic                          req_func,
   input  logic [sctf_pkg::SECTOR_W-1:0] req_sector,
   input  logic                          out_free,
   output logic                          busy,
   output sctf_pkg::rsp_item_type        rsp_item,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [sctf_pkg::SECTOR_W-1:0] rd_sector,
   input  logic [COUNT_BITS-1:0]         rd_count,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [sctf_pkg::SECTOR_W-1:0] wr_sector,
   output logic [COUNT_BITS-1:0]         wr_count
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              fill_cnt_ff, fill_cnt_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic                          func_ff;
   logic [sctf_pkg::SECTOR_W-1:0] sector_ff;
   logic [CNT_W-1:0]              rd_cnt_ff;
   logic [IDX_W-1:0]              chk_idx_ff;
   logic                          found_ff;
   logic [IDX_W-1:0]              hit_idx_ff;
   logic [COUNT_BITS-1:0]         hit_cnt_ff;
   logic [IDX_W-1:0]              min_idx_ff;
   logic [COUNT_BITS-1:0]         min_cnt_ff;

   logic                          match;
   logic                          lower;
   logic                          issue;
   logic                          full;
   logic                          fire;
   logic                          alloc;
   logic [IDX_W-1:0]              sel_idx;
   logic [COUNT_BITS-1:0]         base_cnt;
   logic [IDX_W+sctf_pkg::SLOT_W-1:0] slot_ext;

   // shared compare unit: tag equality and count order on the slot just read
   assign match = chk_vld_ff && (rd_sector == sector_ff);
   assign lower = chk_vld_ff && ((chk_idx_ff == '0) || (rd_count < min_cnt_ff));

   // valid slots always form a prefix, so only slots below the fill count are read
   assign issue   = (state_ff == ST_SCAN) && (rd_cnt_ff < fill_cnt_ff) && !match;
   assign rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign full    = (fill_cnt_ff == CNT_W'(SLOTS));
   assign busy    = (state_ff != ST_IDLE);

   assign fire  = (state_ff == ST_FINISH) && out_free;
   assign alloc = !found_ff && !func_ff;

   always_comb begin
      if (found_ff) begin
         sel_idx  = hit_idx_ff;
         base_cnt = hit_cnt_ff;
      end else if (full) begin
         sel_idx  = min_idx_ff;
         base_cnt = min_cnt_ff;
      end else begin
         sel_idx  = fill_cnt_ff[IDX_W-1:0];
         base_cnt = '0;
      end
   end

   // saturating increment
   assign wr_count  = (&base_cnt) ? base_cnt : base_cnt + 1'b1;
   assign wr_en     = fire && (found_ff || alloc);
   assign wr_addr   = sel_idx;
   assign wr_sector = sector_ff;

   assign slot_ext = {{sctf_pkg::SLOT_W{1'b0}}, sel_idx};

   always_comb begin
      rsp_item.load        = fire;
      rsp_item.hit         = found_ff;
      rsp_item.slot        = (found_ff || alloc) ? slot_ext[sctf_pkg::SLOT_W-1:0] : '0;
      rsp_item.fill        = alloc;
      rsp_item.evicted     = alloc && full;
      rsp_item.disk_access = func_ff || !found_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!issue) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign fill_cnt_in = (fire && alloc && !full) ? fill_cnt_ff + 1'b1 : fill_cnt_ff;
   assign chk_vld_in  = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_cnt_ff <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_cnt_ff <= fill_cnt_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= req_func;
         sector_ff <= req_sector;
         rd_cnt_ff <= '0;
         found_ff  <= 1'b0;
      end else begin
         if (issue) rd_cnt_ff <= rd_cnt_ff + 1'b1;
         if (match) begin
            found_ff   <= 1'b1;
            hit_idx_ff <= chk_idx_ff;
            hit_cnt_ff <= rd_count;
         end
      end
      chk_idx_ff <= rd_cnt_ff[IDX_W-1:0];
      if (lower) begin
         min_idx_ff <= chk_idx_ff;
         min_cnt_ff <= rd_count;
      end
   end

endmodule

>>> hw/rtl/sector_cache_frequency_tags_core.sv
// top level of the least frequently used sector cache tag manager
//
//  channel  | direction | ports                                   | moves
//  ---------+-----------+-----------------------------------------+----------------------
//  req      | in        | req_valid req_stall req_func req_sector | one lookup item
//  rsp      | out       | rsp_valid rsp_stall rsp_hit rsp_slot    | one result item
//           |           | rsp_fill rsp_evicted rsp_disk_access    |
//
// the scan reads one slot per cycle from the tag memory and stops early on a hit
// req_stall stays high from acceptance until the result is loaded into the output register
// a new item is taken while a finished result still waits behind rsp_stall
// reset is synchronous and empties the cache
module sector_cache_frequency_tags_core #(
   parameter int SLOTS      = 10,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [sctf_pkg::SECTOR_W-1:0] req_sector,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [sctf_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                          rsp_fill,
   output logic                          rsp_evicted,
   output logic                          rsp_disk_access
);

   // slot index width and a fill count that can reach SLOTS itself
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   logic                          req_accept;
   logic                          busy;
   logic                          out_free;
   sctf_pkg::rsp_item_type        rsp_item;
   logic [IDX_W-1:0]              rd_addr;
   logic [sctf_pkg::SECTOR_W-1:0] rd_sector;
   logic [COUNT_BITS-1:0]         rd_count;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [sctf_pkg::SECTOR_W-1:0] wr_sector;
   logic [COUNT_BITS-1:0]         wr_count;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   sctf_pkg::rsp_item_type        rsp_data_ff;

   // the sequencer holds the request side off for the whole scan
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   // the result register frees up when empty or when its item leaves this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   sctf_scan #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_func   (req_func),
      .req_sector (req_sector),
      .out_free   (out_free),
      .busy       (busy),
      .rsp_item   (rsp_item),
      .rd_addr    (rd_addr),
      .rd_sector  (rd_sector),
      .rd_count   (rd_count),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_sector  (wr_sector),
      .wr_count   (wr_count)
   );

   sctf_tag_store #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_sector (rd_sector),
      .rd_count  (rd_count),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_sector (wr_sector),
      .wr_count  (wr_count)
   );

   // result stays put while stalled, new one loads only when the slot is free
   assign rsp_valid_in = rsp_item.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_item.load) begin
         rsp_data_ff <= rsp_item;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_data_ff.hit;
   assign rsp_slot        = rsp_data_ff.slot;
   assign rsp_fill        = rsp_data_ff.fill;
   assign rsp_evicted     = rsp_data_ff.evicted;
   assign rsp_disk_access = rsp_data_ff.disk_access;

endmodule

>>> hw/rtl/sctf_checker.sv
// port level checks for the sector cache tag manager, bound to the top level
module sctf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_hit,
   input logic [sctf_pkg::SLOT_W-1:0]   rsp_slot,
   input logic                          rsp_fill,
   input logic                          rsp_evicted,
   input logic                          rsp_disk_access
);

   // an accepted item keeps the request side closed in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken back to back");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hit) && $stable(rsp_slot)
         && $stable(rsp_fill) && $stable(rsp_evicted) && $stable(rsp_disk_access)))
      else $error("stalled result changed");

   // a fill is always a miss that goes to the disk
   a_fill_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fill) |-> (!rsp_hit && rsp_disk_access))
      else $error("fill flagged on a hit or without disk access");

   // an eviction only comes with a fill, and a miss always goes to the disk
   a_evict_needs_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_evicted || rsp_fill) && (rsp_hit || rsp_disk_access)))
      else $error("eviction without fill or miss without disk access");

endmodule

bind sector_cache_frequency_tags_core sctf_checker u_sctf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_slot        (rsp_slot),
   .rsp_fill        (rsp_fill),
   .rsp_evicted     (rsp_evicted),
   .rsp_disk_access (rsp_disk_access)
);

>>> test/sector_cache_frequency_tags_core_tb.sv
// self-checking testbench for the least frequently used sector cache tag manager
module sector_cache_frequency_tags_core_tb;

   // the block runs with its default parameters
   localparam int SLOTS        = 10;
   localparam int COUNT_BITS   = 16;
   localparam int RANDOM_ITEMS = 1126;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOT_SECTORS  = 14;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = SLOTS + 8;
   localparam int SECTOR_MAX   = (1 << sctf_pkg::SECTOR_W) - 1;

   typedef enum logic {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } sector_func_type;

   typedef struct packed {
      logic                        hit;
      logic [sctf_pkg::SLOT_W-1:0] slot;
      logic                        fill;
      logic                        evicted;
      logic                        disk_access;
   } lookup_result_type;

   // tag store model plus the queue of lookups still waiting for their result item
   class lookup_scoreboard_type;
      bit                          line_valid  [SLOTS];
      bit [sctf_pkg::SECTOR_W-1:0] line_sector [SLOTS];
      bit [COUNT_BITS-1:0]         line_uses   [SLOTS];
      lookup_result_type           awaited_lookups [$];
      int                          errors;

      function bit [COUNT_BITS-1:0] bumped(bit [COUNT_BITS-1:0] uses);
         return (uses == '1) ? uses : uses + 1'b1;
      endfunction

      function int pending();
         return awaited_lookups.size();
      endfunction

      // apply one accepted request to the tag store and queue its outcome
      function void predict_lookup(sector_func_type func,
                                   bit [sctf_pkg::SECTOR_W-1:0] sector);
         lookup_result_type r;
         int                found;
         int                pick;
         r     = '0;
         found = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (found < 0 && line_valid[i] && line_sector[i] == sector) found = i;
         end
         if (found >= 0) begin
            line_uses[found] = bumped(line_uses[found]);
            r.hit            = 1'b1;
            r.slot           = sctf_pkg::SLOT_W'(found);
            r.disk_access    = (func == FUNC_WRITE);
         end else if (func == FUNC_WRITE) begin
            // write miss leaves the cache alone
            r.disk_access = 1'b1;
         end else begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
               if (pick < 0 && !line_valid[i]) pick = i;
            end
            if (pick < 0) begin
               // full: smallest count wins, lowest index on ties
               pick = 0;
               for (int i = 1; i < SLOTS; i++) begin
                  if (line_uses[i] < line_uses[pick]) pick = i;
               end
               r.evicted = 1'b1;
            end
            line_valid[pick]  = 1'b1;
            line_sector[pick] = sector;
            // new entry inherits the victim's count
            line_uses[pick]   = bumped(line_uses[pick]);
            r.slot            = sctf_pkg::SLOT_W'(pick);
            r.fill            = 1'b1;
            r.disk_access     = 1'b1;
         end
         awaited_lookups.push_back(r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("field %s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(lookup_result_type got);
         lookup_result_type want;
         if (awaited_lookups.size() == 0) begin
            $error("result item with no lookup pending (slot %0d)", got.slot);
            errors++;
            return;
         end
         want = awaited_lookups.pop_front();
         compare_field("hit", want.hit, got.hit);
         compare_field("slot", want.slot, got.slot);
         compare_field("fill", want.fill, got.fill);
         compare_field("evicted", want.evicted, got.evicted);
         compare_field("disk_access", want.disk_access, got.disk_access);
      endfunction
   endclass

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic                          req_func        = 1'b0;
   logic [sctf_pkg::SECTOR_W-1:0] req_sector      = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic                          rsp_hit;
   logic [sctf_pkg::SLOT_W-1:0]   rsp_slot;
   logic                          rsp_fill;
   logic                          rsp_evicted;
   logic                          rsp_disk_access;

   lookup_scoreboard_type         sb;
   bit                            tail_quiet = 1'b0;
   int                            stall_left = 0;
   int                            quiet_cycles = 0;
   bit                            moved;
   lookup_result_type             seen_rsp;
   bit [sctf_pkg::SECTOR_W-1:0]   hot_sectors [HOT_SECTORS];

   sector_cache_frequency_tags_core #(
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sector      (req_sector),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_fill        (rsp_fill),
      .rsp_evicted     (rsp_evicted),
      .rsp_disk_access (rsp_disk_access)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side back-pressure in random bursts, none during the tail
   always @(posedge clock) begin
      if (reset || tail_quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 7) == 0) stall_left = int'($urandom_range(1, 15));
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.hit         = rsp_hit;
            seen_rsp.slot        = rsp_slot;
            seen_rsp.fill        = rsp_fill;
            seen_rsp.evicted     = rsp_evicted;
            seen_rsp.disk_access = rsp_disk_access;
            sb.check_result(seen_rsp);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.predict_lookup(sector_func_type'(req_func), req_sector);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sector_cache_frequency_tags_core test failed");
            $finish;
         end
      end
   end

   // present one item and hold it until it is taken; valid stays high afterwards
   task automatic send_lookup(sector_func_type func, bit [sctf_pkg::SECTOR_W-1:0] sector);
      req_valid  <= 1'b1;
      req_func   <= func;
      req_sector <= sector;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(int cycles);
      req_valid  <= 1'b0;
      req_func   <= 1'($urandom_range(0, 1));
      req_sector <= sctf_pkg::SECTOR_W'($urandom_range(0, SECTOR_MAX));
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      sector_func_type             func;
      bit [sctf_pkg::SECTOR_W-1:0] sector;
      int                          pick;
      sb = new();
      foreach (hot_sectors[i]) begin
         hot_sectors[i] = sctf_pkg::SECTOR_W'($urandom_range(0, SECTOR_MAX));
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: write miss into an empty cache, then fill every slot
      send_lookup(FUNC_WRITE, 10'd0);
      send_lookup(FUNC_READ, 10'd0);
      send_lookup(FUNC_READ, 10'd1023);
      for (int b = 0; b < 8; b++) send_lookup(FUNC_READ, sctf_pkg::SECTOR_W'(1 << b));
      // read hit and write hit
      send_lookup(FUNC_READ, 10'd1023);
      send_lookup(FUNC_WRITE, 10'd1023);
      // hammer one slot well ahead of the others
      repeat (7) send_lookup(FUNC_READ, 10'd0);
      send_lookup(FUNC_WRITE, 10'd0);
      // write miss on a full cache, an eviction on a count tie, then two read hits
      send_lookup(FUNC_WRITE, 10'd512);
      send_lookup(FUNC_READ, 10'd256);
      send_lookup(FUNC_READ, 10'd2);
      send_lookup(FUNC_READ, 10'd256);
      wait_for_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - TAIL_ITEMS) tail_quiet <= 1'b1;
         if (n == RANDOM_ITEMS / 2) wait_for_results();
         func = ($urandom_range(0, 3) == 0) ? FUNC_WRITE : FUNC_READ;
         // mostly a working set a bit larger than the cache, some cold sectors
         pick = int'($urandom_range(0, HOT_SECTORS - 1));
         if ($urandom_range(0, 19) == 0) begin
            hot_sectors[pick] = sctf_pkg::SECTOR_W'($urandom_range(0, SECTOR_MAX));
         end
         if ($urandom_range(0, 5) == 0) begin
            sector = sctf_pkg::SECTOR_W'($urandom_range(0, SECTOR_MAX));
         end else begin
            sector = hot_sectors[pick];
         end
         send_lookup(func, sector);
         if (n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 4) == 0)
            idle_req(int'($urandom_range(1, 15)));
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("sector_cache_frequency_tags_core test passed");
      end else begin
         $display("sector_cache_frequency_tags_core test failed");
      end
      $finish;
   end

endmodule
